// File: hw/rtl/ttcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcp_pkg
// Types, constants and arithmetic helpers of the triangle transform, cull
// and projection core.
// ----------------------------------------------------------------------------
package ttcp_pkg;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by_coord;
        logic signed [31:0] bz;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
    } t_req;

    typedef struct packed {
        logic signed [31:0] sx0;
        logic signed [31:0] sy0;
        logic signed [31:0] sx1;
        logic signed [31:0] sy1;
        logic signed [31:0] sx2;
        logic signed [31:0] sy2;
        logic signed [31:0] depth0;
        logic signed [31:0] depth1;
        logic signed [31:0] depth2;
        logic signed [15:0] luminance;
    } t_res;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] dz;
    } t_lane_out;

    typedef struct packed {
        logic               keep;
        logic signed [15:0] lum;
    } t_norm_out;

    typedef struct packed {
        logic        [31:0] rot_z;
        logic        [31:0] rot_x;
        logic        [30:0] proj_x_scale;
        logic        [30:0] proj_y_scale;
        logic        [30:0] depth_scale;
        logic signed [31:0] depth_offset;
        logic        [11:0] vp_hw;
        logic        [11:0] vp_hh;
    } t_cfg;

    localparam logic [2:0] CFG_ROT_Z   = 3'd0;
    localparam logic [2:0] CFG_ROT_X   = 3'd1;
    localparam logic [2:0] CFG_PROJ_X  = 3'd2;
    localparam logic [2:0] CFG_PROJ_Y  = 3'd3;
    localparam logic [2:0] CFG_DEPTH_S = 3'd4;
    localparam logic [2:0] CFG_DEPTH_O = 3'd5;
    localparam logic [2:0] CFG_VP_W    = 3'd6;
    localparam logic [2:0] CFG_VP_H    = 3'd7;

    localparam int ROT_FRAC  = 14;
    localparam int LANE_QW   = 32;
    localparam int LUM_QW    = 17;
    localparam int SQ_STG    = 30;
    localparam int ROT_LAT   = 4;
    localparam int LANE_LAT  = ROT_LAT + 3 + (LANE_QW + 1) + 3;
    localparam int NORM_LAT  = 9 + SQ_STG + 1 + (LUM_QW + 1) + 1;
    localparam int TOTAL_LAT = ROT_LAT + NORM_LAT;
    localparam int ALIGN_LAT = TOTAL_LAT - LANE_LAT;

    localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

    // add half an LSB, then floor
    function automatic logic signed [79:0] f_rshr(input logic signed [79:0] v,
                                                  input int unsigned n);
        logic signed [79:0] half;
        half = 80'sd1 <<< (n - 1);
        return (v + half) >>> n;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [79:0] v);
        logic signed [31:0] res;
        if (v > 80'sh7FFF_FFFF) begin
            res = INT32_MAX;
        end else if (v < -80'sh8000_0000) begin
            res = INT32_MIN;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/triangle_transform_cull_project_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_transform_cull_project_core
// Rotates, back-face culls and projects one triangle per clock.
// ----------------------------------------------------------------------------
// A triangle is taken on every cycle that i_start is high; o_busy never
// rises. Each kept triangle shows its result on o_res for one cycle with
// o_valid high, in the order of the requests; culled triangles produce no
// strobe. The latency is set by the normal path: the 30-stage square root
// and the 18-stage luminance divider behind the cross product; the three
// vertex lanes, each with a 33-stage divider, are delayed to match. The
// receiver cannot stall the results.
module triangle_transform_cull_project_core
    import ttcp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_req        i_req,
    output logic        o_valid,
    output t_res        o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot_z        <= 32'h4000_0000;
            r_cfg.rot_x        <= 32'h4000_0000;
            r_cfg.proj_x_scale <= 31'd65536;
            r_cfg.proj_y_scale <= 31'd65536;
            r_cfg.depth_scale  <= 31'd65543;
            r_cfg.depth_offset <= -32'sd6554;
            r_cfg.vp_hw        <= 12'd320;
            r_cfg.vp_hh        <= 12'd240;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROT_Z:   r_cfg.rot_z        <= i_cfg_data;
                CFG_ROT_X:   r_cfg.rot_x        <= i_cfg_data;
                CFG_PROJ_X:  r_cfg.proj_x_scale <= i_cfg_data[30:0];
                CFG_PROJ_Y:  r_cfg.proj_y_scale <= i_cfg_data[30:0];
                CFG_DEPTH_S: r_cfg.depth_scale  <= i_cfg_data[30:0];
                CFG_DEPTH_O: r_cfg.depth_offset <= i_cfg_data;
                CFG_VP_W:    r_cfg.vp_hw        <= i_cfg_data[11:0];
                CFG_VP_H:    r_cfg.vp_hh        <= i_cfg_data[11:0];
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic                 s_acc;
    logic [TOTAL_LAT-1:0] r_vld;

    assign s_acc = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], s_acc};
        end
    end

    t_vec      s_in   [0:2];
    t_vec      s_vert [0:2];
    t_lane_out s_pt   [0:2];
    t_lane_out r_dly  [0:2][0:ALIGN_LAT-1];
    t_norm_out s_norm;

    assign s_in[0] = '{x: i_req.ax, y: i_req.ay,       z: i_req.az};
    assign s_in[1] = '{x: i_req.bx, y: i_req.by_coord, z: i_req.bz};
    assign s_in[2] = '{x: i_req.cx, y: i_req.cy,       z: i_req.cz};

    for (genvar i = 0; i < 3; i++) begin : g_lane
        ttcp_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_cfg  (r_cfg),
            .i_vert (s_in[i]),
            .o_vert (s_vert[i]),
            .o_pt   (s_pt[i])
        );

        // hold lane points until the luminance catches up
        always_ff @(posedge i_clk) begin
            r_dly[i][0] <= s_pt[i];
            for (int k = 1; k < ALIGN_LAT; k++) begin
                r_dly[i][k] <= r_dly[i][k-1];
            end
        end
    end

    ttcp_norm u_norm (
        .i_clk (i_clk),
        .i_v0  (s_vert[0]),
        .i_v1  (s_vert[1]),
        .i_v2  (s_vert[2]),
        .o_res (s_norm)
    );

    logic r_valid;
    t_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_vld[TOTAL_LAT-1] && s_norm.keep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.sx0       <= r_dly[0][ALIGN_LAT-1].sx;
        r_res.sy0       <= r_dly[0][ALIGN_LAT-1].sy;
        r_res.sx1       <= r_dly[1][ALIGN_LAT-1].sx;
        r_res.sy1       <= r_dly[1][ALIGN_LAT-1].sy;
        r_res.sx2       <= r_dly[2][ALIGN_LAT-1].sx;
        r_res.sy2       <= r_dly[2][ALIGN_LAT-1].sy;
        r_res.depth0    <= r_dly[0][ALIGN_LAT-1].dz;
        r_res.depth1    <= r_dly[1][ALIGN_LAT-1].dz;
        r_res.depth2    <= r_dly[2][ALIGN_LAT-1].dz;
        r_res.luminance <= s_norm.lum;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: hw/rtl/ttcp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcp_div
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit in QW bits.
// ----------------------------------------------------------------------------
module ttcp_div #(
    parameter int NW = 50,
    parameter int DW = 33,
    parameter int QW = 32,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf,
    output logic [TW-1:0] o_tag
);
    localparam int HW = NW - QW;
    localparam int CW = ((HW > DW) ? HW : DW) + 1;

    logic [DW-1:0] r_rem [0:QW];
    logic [QW-1:0] r_nq  [0:QW];
    logic [DW-1:0] r_den [0:QW];
    logic          r_ovf [0:QW];
    logic [TW-1:0] r_tag [0:QW];

    // the upper part of the numerator seeds the remainder
    always_ff @(posedge i_clk) begin
        r_rem[0] <= DW'(i_num[NW-1:QW]);
        r_nq[0]  <= i_num[QW-1:0];
        r_den[0] <= i_den;
        r_ovf[0] <= CW'(i_num[NW-1:QW]) >= CW'(i_den);
        r_tag[0] <= i_tag;
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0] s_trial;
        logic        s_qb;
        assign s_trial = {r_rem[k], r_nq[k][QW-1]};
        assign s_qb    = s_trial >= {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= s_qb ? DW'(s_trial - {1'b0, r_den[k]}) : s_trial[DW-1:0];
            r_nq[k+1]  <= {r_nq[k][QW-2:0], s_qb};
            r_den[k+1] <= r_den[k];
            r_ovf[k+1] <= r_ovf[k];
            r_tag[k+1] <= r_tag[k];
        end
    end

    assign o_quo = r_nq[QW];
    assign o_ovf = r_ovf[QW];
    assign o_tag = r_tag[QW];

endmodule

// File: hw/rtl/ttcp_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcp_isqrt
// Pipelined floor square root of a 60-bit value, two radicand bits per stage.
// ----------------------------------------------------------------------------
module ttcp_isqrt
    import ttcp_pkg::*;
#(
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic [59:0]   i_val,
    input  logic [TW-1:0] i_tag,
    output logic [30:0]   o_root,
    output logic [TW-1:0] o_tag
);
    logic [59:0]   r_v   [1:SQ_STG];
    logic [59:0]   r_r   [1:SQ_STG];
    logic [TW-1:0] r_tag [1:SQ_STG];

    for (genvar k = 0; k < SQ_STG; k++) begin : g_stage
        localparam logic [59:0] BIT = 60'd1 << (58 - 2 * k);
        logic [59:0]   s_v;
        logic [59:0]   s_r;
        logic [TW-1:0] s_tag;
        logic [59:0]   s_t;
        if (k == 0) begin : g_first
            assign s_v   = i_val;
            assign s_r   = '0;
            assign s_tag = i_tag;
        end else begin : g_next
            assign s_v   = r_v[k];
            assign s_r   = r_r[k];
            assign s_tag = r_tag[k];
        end
        assign s_t = s_r + BIT;
        always_ff @(posedge i_clk) begin
            if (s_v >= s_t) begin
                r_v[k+1] <= s_v - s_t;
                r_r[k+1] <= (s_r >> 1) + BIT;
            end else begin
                r_v[k+1] <= s_v;
                r_r[k+1] <= s_r >> 1;
            end
            r_tag[k+1] <= s_tag;
        end
    end

    assign o_root = r_r[SQ_STG][30:0];
    assign o_tag  = r_tag[SQ_STG];

endmodule

// File: hw/rtl/ttcp_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcp_lane
// One vertex: Z then X rotation, z offset, projection, perspective divide
// and viewport scaling.
// ----------------------------------------------------------------------------
module ttcp_lane
    import ttcp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  t_cfg      i_cfg,
    input  t_vec      i_vert,
    output t_vec      o_vert,
    output t_lane_out o_pt
);
    localparam int NW = 34 + FRAC_BITS;
    localparam int TW = 34;
    localparam logic signed [32:0] ONE  = 33'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] ZOFF = 32'sd8 <<< FRAC_BITS;

    function automatic logic signed [31:0] f_pick(input logic signed [31:0] p,
                                                  input logic [31:0] q,
                                                  input logic ovf,
                                                  input logic neg,
                                                  input logic wz);
        logic signed [31:0] res;
        if (wz) begin
            res = p;
        end else if (ovf) begin
            res = neg ? INT32_MIN : INT32_MAX;
        end else if (neg) begin
            res = (q > 32'h8000_0000) ? INT32_MIN : $signed(32'(32'd0 - q));
        end else begin
            res = (q > 32'h7FFF_FFFF) ? INT32_MAX : $signed(q);
        end
        return res;
    endfunction

    // rotation about Z
    logic signed [15:0] s_cz, s_sz, s_cx, s_sx;
    logic signed [47:0] r_xc, r_ys, r_xs, r_yc;
    logic signed [31:0] r_z1;
    logic signed [48:0] s_d1, s_a1;
    logic signed [31:0] r_x2, r_y2, r_z2;

    assign s_cz = i_cfg.rot_z[31:16];
    assign s_sz = i_cfg.rot_z[15:0];
    assign s_cx = i_cfg.rot_x[31:16];
    assign s_sx = i_cfg.rot_x[15:0];

    always_ff @(posedge i_clk) begin
        r_xc <= i_vert.x * s_cz;
        r_ys <= i_vert.y * s_sz;
        r_xs <= i_vert.x * s_sz;
        r_yc <= i_vert.y * s_cz;
        r_z1 <= i_vert.z;
    end

    assign s_d1 = r_xc - r_ys;
    assign s_a1 = r_xs + r_yc;

    always_ff @(posedge i_clk) begin
        r_x2 <= f_sat32(f_rshr(80'(s_d1), ROT_FRAC));
        r_y2 <= f_sat32(f_rshr(80'(s_a1), ROT_FRAC));
        r_z2 <= r_z1;
    end

    // rotation about X, then the z offset
    logic signed [47:0] r_yc3, r_zs3, r_ys3, r_zc3;
    logic signed [31:0] r_x3;
    logic signed [48:0] s_d3, s_a3;
    logic signed [31:0] s_z4;
    logic signed [32:0] s_z4o;
    t_vec               r_v;

    always_ff @(posedge i_clk) begin
        r_yc3 <= r_y2 * s_cx;
        r_zs3 <= r_z2 * s_sx;
        r_ys3 <= r_y2 * s_sx;
        r_zc3 <= r_z2 * s_cx;
        r_x3  <= r_x2;
    end

    assign s_d3  = r_yc3 - r_zs3;
    assign s_a3  = r_ys3 + r_zc3;
    assign s_z4  = f_sat32(f_rshr(80'(s_a3), ROT_FRAC));
    assign s_z4o = s_z4 + ZOFF;

    always_ff @(posedge i_clk) begin
        r_v.x <= r_x3;
        r_v.y <= f_sat32(f_rshr(80'(s_d3), ROT_FRAC));
        r_v.z <= f_sat32(80'(s_z4o));
    end

    assign o_vert = r_v;

    // projection products
    logic signed [63:0] r_mx, r_my, r_mz;
    logic signed [31:0] r_w1, r_w2;
    logic signed [31:0] r_p [0:2];

    always_ff @(posedge i_clk) begin
        r_mx <= r_v.x * $signed({1'b0, i_cfg.proj_x_scale});
        r_my <= r_v.y * $signed({1'b0, i_cfg.proj_y_scale});
        r_mz <= r_v.z * $signed({1'b0, i_cfg.depth_scale});
        r_w1 <= r_v.z;
    end

    always_ff @(posedge i_clk) begin
        r_p[0] <= f_sat32(f_rshr(80'(r_mx), FRAC_BITS));
        r_p[1] <= f_sat32(f_rshr(80'(r_my), FRAC_BITS));
        r_p[2] <= f_sat32(f_rshr(80'(r_mz), FRAC_BITS) + 80'(i_cfg.depth_offset));
        r_w2   <= r_w1;
    end

    // divide by w: (2|p|*one + |w|) / (2|w|)
    logic [31:0]    s_aw;
    logic [NW-1:0]  r_num [0:2];
    logic [32:0]    r_den;
    logic [TW-1:0]  r_tag [0:2];
    logic [31:0]    s_q   [0:2];
    logic           s_ovf [0:2];
    logic [TW-1:0]  s_tag [0:2];
    logic signed [31:0] r_sel [0:2];

    assign s_aw = r_w2[31] ? 32'(32'd0 - r_w2) : r_w2;

    for (genvar c = 0; c < 3; c++) begin : g_ch
        logic [31:0]   s_ap;
        logic [NW-1:0] s_un;
        assign s_ap = r_p[c][31] ? 32'(32'd0 - r_p[c]) : r_p[c];
        assign s_un = NW'(s_ap) << (FRAC_BITS + 1);

        always_ff @(posedge i_clk) begin
            r_num[c] <= s_un + NW'(s_aw);
            r_tag[c] <= {r_p[c], r_p[c][31] ^ r_w2[31], r_w2 == 32'sd0};
        end

        ttcp_div #(
            .NW (NW),
            .DW (33),
            .QW (LANE_QW),
            .TW (TW)
        ) u_div (
            .i_clk (i_clk),
            .i_num (r_num[c]),
            .i_den (r_den),
            .i_tag (r_tag[c]),
            .o_quo (s_q[c]),
            .o_ovf (s_ovf[c]),
            .o_tag (s_tag[c])
        );

        always_ff @(posedge i_clk) begin
            r_sel[c] <= f_pick(s_tag[c][33:2], s_q[c], s_ovf[c], s_tag[c][1], s_tag[c][0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_den <= {s_aw, 1'b0};
    end

    // viewport
    logic signed [32:0] s_ox, s_oy;
    logic signed [45:0] r_vx, r_vy;
    logic signed [31:0] r_dz;
    t_lane_out          r_out;

    assign s_ox = r_sel[0] + ONE;
    assign s_oy = r_sel[1] + ONE;

    always_ff @(posedge i_clk) begin
        r_vx <= s_ox * $signed({1'b0, i_cfg.vp_hw});
        r_vy <= s_oy * $signed({1'b0, i_cfg.vp_hh});
        r_dz <= r_sel[2];
    end

    always_ff @(posedge i_clk) begin
        r_out.sx <= f_sat32(80'(r_vx));
        r_out.sy <= f_sat32(80'(r_vy));
        r_out.dz <= r_dz;
    end

    assign o_pt = r_out;

endmodule

// File: hw/rtl/ttcp_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcp_norm
// Merge stage: face normal, block normalization, back-face test and
// luminance of the triangle formed by the three lanes.
// ----------------------------------------------------------------------------
module ttcp_norm
    import ttcp_pkg::*;
(
    input  logic      i_clk,
    input  t_vec      i_v0,
    input  t_vec      i_v1,
    input  t_vec      i_v2,
    output t_norm_out o_res
);
    // edges
    logic signed [32:0] s_e1 [0:2];
    logic signed [32:0] s_e2 [0:2];
    logic signed [31:0] r_l1 [0:2];
    logic signed [31:0] r_l2 [0:2];
    t_vec               r_v0 [1:8];

    assign s_e1[0] = i_v1.x - i_v0.x;
    assign s_e1[1] = i_v1.y - i_v0.y;
    assign s_e1[2] = i_v1.z - i_v0.z;
    assign s_e2[0] = i_v2.x - i_v0.x;
    assign s_e2[1] = i_v2.y - i_v0.y;
    assign s_e2[2] = i_v2.z - i_v0.z;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_l1[j] <= f_sat32(80'(s_e1[j]));
            r_l2[j] <= f_sat32(80'(s_e2[j]));
        end
        r_v0[1] <= i_v0;
        for (int k = 2; k <= 8; k++) begin
            r_v0[k] <= r_v0[k-1];
        end
    end

    // cross product
    logic signed [63:0] r_pa [0:2];
    logic signed [63:0] r_pb [0:2];
    logic signed [63:0] r_n  [0:2];

    always_ff @(posedge i_clk) begin
        r_pa[0] <= r_l1[1] * r_l2[2];
        r_pb[0] <= r_l1[2] * r_l2[1];
        r_pa[1] <= r_l1[2] * r_l2[0];
        r_pb[1] <= r_l1[0] * r_l2[2];
        r_pa[2] <= r_l1[0] * r_l2[1];
        r_pb[2] <= r_l1[1] * r_l2[0];
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_n[j] <= r_pa[j] - r_pb[j];
        end
    end

    // largest magnitude
    logic [63:0]        s_mag [0:2];
    logic [63:0]        s_m01;
    logic [63:0]        r_max;
    logic signed [63:0] r_n4 [0:2];
    logic signed [63:0] r_n5 [0:2];
    logic signed [63:0] r_n6 [0:2];

    for (genvar j = 0; j < 3; j++) begin : g_mag
        assign s_mag[j] = r_n[j][63] ? 64'(64'd0 - r_n[j]) : r_n[j];
    end
    assign s_m01 = (s_mag[0] > s_mag[1]) ? s_mag[0] : s_mag[1];

    always_ff @(posedge i_clk) begin
        r_max <= (s_m01 > s_mag[2]) ? s_m01 : s_mag[2];
        r_n4  <= r_n;
    end

    // leading one, a byte at a time
    logic [7:0] r_bnz;
    logic [2:0] r_bpos [0:7];
    logic [2:0] s_bpos [0:7];

    always_comb begin
        for (int g = 0; g < 8; g++) begin
            s_bpos[g] = '0;
            for (int b = 0; b < 8; b++) begin
                if (r_max[8*g + b]) begin
                    s_bpos[g] = 3'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < 8; g++) begin
            r_bnz[g]  <= |r_max[8*g +: 8];
            r_bpos[g] <= s_bpos[g];
        end
        r_n5 <= r_n4;
    end

    logic [5:0] s_lead;
    logic [5:0] r_lead;
    logic       r_zero6, r_zero7, r_zero8;

    always_comb begin
        s_lead = '0;
        for (int g = 0; g < 8; g++) begin
            if (r_bnz[g]) begin
                s_lead = {3'(g), r_bpos[g]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lead  <= s_lead;
        r_zero6 <= ~|r_bnz;
        r_n6    <= r_n5;
    end

    // scale so the largest magnitude lands in [2^28, 2^29)
    logic [5:0]         s_dn, s_up;
    logic signed [31:0] r_nn [0:2];

    assign s_dn = r_lead - 6'd28;
    assign s_up = 6'd28 - r_lead;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            if (r_lead > 6'd28) begin
                r_nn[j] <= 32'(r_n6[j] >>> s_dn);
            end else begin
                r_nn[j] <= 32'(r_n6[j] <<< s_up);
            end
        end
        r_zero7 <= r_zero6;
    end

    // facing test and squared length
    logic signed [63:0] r_dt [0:2];
    logic signed [63:0] r_sq [0:2];
    logic signed [31:0] r_nz8;
    logic signed [63:0] s_dot;
    logic signed [63:0] s_sqs;
    logic               r_keep9;
    logic [59:0]        r_sqs9;
    logic signed [31:0] r_nz9;

    always_ff @(posedge i_clk) begin
        r_dt[0] <= r_nn[0] * r_v0[7].x;
        r_dt[1] <= r_nn[1] * r_v0[7].y;
        r_dt[2] <= r_nn[2] * r_v0[7].z;
        for (int j = 0; j < 3; j++) begin
            r_sq[j] <= r_nn[j] * r_nn[j];
        end
        r_nz8   <= r_nn[2];
        r_zero8 <= r_zero7;
    end

    assign s_dot = r_dt[0] + r_dt[1] + r_dt[2];
    assign s_sqs = r_sq[0] + r_sq[1] + r_sq[2];

    always_ff @(posedge i_clk) begin
        // degenerate triangles have no normal and are dropped
        r_keep9 <= !r_zero8 && s_dot[63];
        r_sqs9  <= s_sqs[59:0];
        r_nz9   <= r_nz8;
    end

    // length
    logic [30:0] s_len;
    logic [32:0] s_sqtag;

    ttcp_isqrt #(
        .TW (33)
    ) u_isqrt (
        .i_clk  (i_clk),
        .i_val  (r_sqs9),
        .i_tag  ({r_keep9, r_nz9}),
        .o_root (s_len),
        .o_tag  (s_sqtag)
    );

    // luminance = -nz * 2^15 / len
    logic signed [31:0] s_nz;
    logic [31:0]        s_anz;
    logic [46:0]        r_lnum;
    logic [31:0]        r_lden;
    logic [1:0]         r_ltag;
    logic [LUM_QW-1:0]  s_lq;
    logic               s_lovf;
    logic [1:0]         s_ltag;
    t_norm_out          r_out;

    assign s_nz  = s_sqtag[31:0];
    assign s_anz = s_nz[31] ? 32'(32'd0 - s_nz) : s_nz;

    always_ff @(posedge i_clk) begin
        r_lnum <= (47'(s_anz[29:0]) << 16) + 47'(s_len);
        r_lden <= {s_len, 1'b0};
        r_ltag <= {s_sqtag[32], !s_nz[31] && (s_nz != 32'sd0)};
    end

    ttcp_div #(
        .NW (47),
        .DW (32),
        .QW (LUM_QW),
        .TW (2)
    ) u_div (
        .i_clk (i_clk),
        .i_num (r_lnum),
        .i_den (r_lden),
        .i_tag (r_ltag),
        .o_quo (s_lq),
        .o_ovf (s_lovf),
        .o_tag (s_ltag)
    );

    always_ff @(posedge i_clk) begin
        r_out.keep <= s_ltag[1];
        if (s_lovf) begin
            r_out.lum <= s_ltag[0] ? -16'sd32768 : 16'sd32767;
        end else if (s_ltag[0]) begin
            r_out.lum <= (s_lq > 17'd32768) ? -16'sd32768 : $signed(16'(17'd0 - s_lq));
        end else begin
            r_out.lum <= (s_lq > 17'd32767) ? 16'sd32767 : $signed(s_lq[15:0]);
        end
    end

    assign o_res = r_out;

endmodule
